// ----- sv/mbdt_pkg.sv -----
// ----------------------------------------------------------------------------
// mbdt_pkg
// Shared constants, codes and types of the Modbus slave data table.
// ----------------------------------------------------------------------------
package mbdt_pkg;

   localparam int STORE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CALC_W      = 17;

   localparam logic [7:0] FC_READ_COILS     = 8'd1;
   localparam logic [7:0] FC_READ_DISCRETE  = 8'd2;
   localparam logic [7:0] FC_READ_HOLDING   = 8'd3;
   localparam logic [7:0] FC_READ_INPUT     = 8'd4;
   localparam logic [7:0] FC_WRITE_COIL     = 8'd5;
   localparam logic [7:0] FC_WRITE_REG      = 8'd6;
   localparam logic [7:0] FC_WRITE_COILS    = 8'd15;
   localparam logic [7:0] FC_WRITE_REGS     = 8'd16;

   localparam logic [1:0] NT_COILS     = 2'd0;
   localparam logic [1:0] NT_DISCRETE  = 2'd1;
   localparam logic [1:0] NT_HOLDING   = 2'd2;
   localparam logic [1:0] NT_INPUT_REG = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_FUNC = 2'd1;
   localparam logic [1:0] ST_BAD_ADDR = 2'd2;

   localparam logic [1:0] CSR_NODE_TYPE     = 2'd0;
   localparam logic [1:0] CSR_WINDOW_START  = 2'd1;
   localparam logic [1:0] CSR_WINDOW_LENGTH = 2'd2;

   typedef struct packed {
      logic [1:0]        status;
      logic              wr_en;
      logic              rd_en;
      logic              rd_word;
      logic [ADDR_W-1:0] idx;
      logic [15:0]       wr_data;
   } chk_type;

endpackage

// ----- sv/modbus_slave_data_table_unit.sv -----
// ----------------------------------------------------------------------------
// modbus_slave_data_table_unit
// One element of a Modbus request per transfer against a cleared data store.
// ----------------------------------------------------------------------------
// The req_ channel carries one element of a request per transfer. The block
// checks the function code and the address window, then reads or writes one
// entry of a single-port synchronous store of STORE_DEPTH words.
// The rsp_ channel returns one status and read value per request transfer.
// The response is registered: each request passes through the middle
// stage and then the response register before rsp_tvalid rises.
// Throughput is one item per cycle while the receiver does not stall,
// set by the one store access per item; a write followed by a read of the
// same entry sees the new value because the store write lands at the
// acceptance edge of the writing item.
// After reset the store is cleared one entry per cycle, all STORE_DEPTH
// entries (1024 by default), and req_tready stays low during that pass. The csr_
// port takes writes at any time, also during the clear.
// When the receiver stalls, the response register holds, the middle stage
// holds with its read data, and req_tready falls until space frees up.
// ----------------------------------------------------------------------------
module modbus_slave_data_table_unit
   import mbdt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // function_code[7:0], start_address[23:8], quantity[34:24],
   // element_offset[45:35], write_value[61:46], zero fill [63:62]
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], read_value[17:2], zero fill [23:18]
   output logic [23:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [1:0]        node_type_ff;
   logic [15:0]       window_start_ff;
   logic [10:0]       window_length_ff;

   logic              clr_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;

   logic [15:0]       mem [STORE_DEPTH];
   logic [15:0]       mem_rd_ff;

   logic              s1_vld_ff;
   logic [1:0]        s1_status_ff;
   logic              s1_rd_ff;
   logic              s1_word_ff;

   logic              rsp_vld_ff;
   logic [17:0]       rsp_data_ff;
   logic [17:0]       rsp_data_in;

   chk_type           chk;
   logic              accept;
   logic              s1_go;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [15:0]       mem_wdata;

   mbdt_check u_check (
      .node_type      (node_type_ff),
      .window_start   (window_start_ff),
      .window_length  (window_length_ff),
      .function_code  (req_tdata[7:0]),
      .start_address  (req_tdata[23:8]),
      .quantity       (req_tdata[34:24]),
      .element_offset (req_tdata[45:35]),
      .write_value    (req_tdata[61:46]),
      .chk            (chk)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         node_type_ff     <= NT_COILS;
         window_start_ff  <= 16'd0;
         window_length_ff <= 11'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NODE_TYPE:     node_type_ff     <= csr_wdata[1:0];
            CSR_WINDOW_START:  window_start_ff  <= csr_wdata;
            CSR_WINDOW_LENGTH: window_length_ff <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
      end else if (clr_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == ADDR_W'(STORE_DEPTH - 1)) begin
            clr_ff <= 1'b0;
         end
      end
   end

   assign s1_go      = s1_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !clr_ff && (!s1_vld_ff || s1_go);
   assign accept     = req_tvalid && req_tready;

   assign mem_we    = clr_ff || (accept && chk.wr_en);
   assign mem_waddr = clr_ff ? clr_cnt_ff : chk.idx;
   assign mem_wdata = clr_ff ? 16'd0 : chk.wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (accept) begin
         mem_rd_ff <= mem[chk.idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (accept) begin
         s1_vld_ff <= 1'b1;
      end else if (s1_go) begin
         s1_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_status_ff <= chk.status;
         s1_rd_ff     <= chk.rd_en;
         s1_word_ff   <= chk.rd_word;
      end
   end

   always_comb begin
      rsp_data_in = {16'd0, s1_status_ff};
      if (s1_rd_ff) begin
         rsp_data_in[17:2] = s1_word_ff ? mem_rd_ff : {15'd0, mem_rd_ff[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (s1_go) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff};

   property p_no_accept_in_clear;
      @(posedge clock) disable iff (reset) clr_ff |-> !req_tready;
   endproperty
   a_no_accept_in_clear: assert property (p_no_accept_in_clear)
      else $error("request transfer taken during the store clear");

   property p_stage_holds;
      @(posedge clock) disable iff (reset) (s1_vld_ff && !s1_go) |=> s1_vld_ff;
   endproperty
   a_stage_holds: assert property (p_stage_holds)
      else $error("stalled item lost from the middle stage");

   property p_accept_fills_stage;
      @(posedge clock) disable iff (reset) accept |=> s1_vld_ff;
   endproperty
   a_accept_fills_stage: assert property (p_accept_fills_stage)
      else $error("accepted item did not reach the middle stage");

   property p_error_reads_zero;
      @(posedge clock) disable iff (reset)
         (rsp_vld_ff && (rsp_data_ff[1:0] != ST_OK)) |-> (rsp_data_ff[17:2] == 16'd0);
   endproperty
   a_error_reads_zero: assert property (p_error_reads_zero)
      else $error("error response carries a nonzero read value");

endmodule

// ----- sv/mbdt_check.sv -----
// ----------------------------------------------------------------------------
// mbdt_check
// Decodes one request element: checks the function code against the node
// type, checks the range against the address window and forms the access.
// ----------------------------------------------------------------------------
module mbdt_check
   import mbdt_pkg::*;
(
   input  logic [1:0]  node_type,
   input  logic [15:0] window_start,
   input  logic [10:0] window_length,
   input  logic [7:0]  function_code,
   input  logic [15:0] start_address,
   input  logic [10:0] quantity,
   input  logic [10:0] element_offset,
   input  logic [15:0] write_value,
   output chk_type     chk
);

   logic              allowed;
   logic              single;
   logic [CALC_W-1:0] served;
   logic [CALC_W-1:0] limit;
   logic [CALC_W-1:0] req_end;
   logic [CALC_W-1:0] elem;
   logic [CALC_W-1:0] idx_full;

   always_comb begin
      case (node_type)
         NT_COILS: begin
            allowed = (function_code == FC_READ_COILS) || (function_code == FC_WRITE_COIL) ||
                      (function_code == FC_WRITE_COILS);
         end
         NT_DISCRETE: begin
            allowed = (function_code == FC_READ_DISCRETE);
         end
         NT_HOLDING: begin
            allowed = (function_code == FC_READ_HOLDING) || (function_code == FC_WRITE_REG) ||
                      (function_code == FC_WRITE_REGS);
         end
         default: begin
            allowed = (function_code == FC_READ_INPUT);
         end
      endcase
   end

   assign single = (function_code == FC_WRITE_COIL) || (function_code == FC_WRITE_REG);

   always_comb begin
      if (CALC_W'(window_length) > CALC_W'(STORE_DEPTH)) begin
         served = CALC_W'(STORE_DEPTH);
      end else begin
         served = CALC_W'(window_length);
      end
   end

   assign limit    = CALC_W'(window_start) + served;
   assign req_end  = CALC_W'(start_address) + CALC_W'(quantity);
   assign elem     = single ? CALC_W'(start_address)
                            : CALC_W'(start_address) + CALC_W'(element_offset);
   assign idx_full = elem - CALC_W'(window_start);

   always_comb begin
      chk.status  = ST_OK;
      chk.idx     = idx_full[ADDR_W-1:0];
      chk.rd_word = (function_code == FC_READ_HOLDING) || (function_code == FC_READ_INPUT);
      chk.rd_en   = 1'b0;
      chk.wr_en   = 1'b0;
      case (function_code)
         FC_WRITE_COIL:  chk.wr_data = {15'd0, (write_value != 16'd0)};
         FC_WRITE_COILS: chk.wr_data = {15'd0, write_value[0]};
         default:        chk.wr_data = write_value;
      endcase

      if (!allowed) begin
         chk.status = ST_BAD_FUNC;
      end else if (start_address < window_start) begin
         chk.status = ST_BAD_ADDR;
      end else if (single) begin
         if (CALC_W'(start_address) >= limit) begin
            chk.status = ST_BAD_ADDR;
         end
      end else if ((req_end > limit) || (element_offset >= quantity)) begin
         chk.status = ST_BAD_ADDR;
      end

      if ((chk.status == ST_OK) && (idx_full >= CALC_W'(STORE_DEPTH))) begin
         chk.status = ST_BAD_ADDR;
      end

      if (chk.status == ST_OK) begin
         chk.rd_en = (function_code == FC_READ_COILS) || (function_code == FC_READ_DISCRETE) ||
                     (function_code == FC_READ_HOLDING) || (function_code == FC_READ_INPUT);
         chk.wr_en = !chk.rd_en;
      end
   end

endmodule

// ----- dv/modbus_slave_data_table_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_slave_data_table_unit_tb
// Self-checking bench for the Modbus slave data table unit.
// ----------------------------------------------------------------------------
// A directed list walks the field extremes, every function code, both window
// bounds, zero and oversized windows and read-back across node types. Then
// random phases run mostly well-formed element accesses under new window
// settings, with sender gaps, receiver stalls and one long receiver hold.
// Responses are checked against pinned rows or a bit-accurate store model.
// ----------------------------------------------------------------------------
module modbus_slave_data_table_unit_tb;
   import mbdt_pkg::*;

   localparam logic [1:0] CSR_UNUSED       = 2'd3;
   localparam logic [7:0] FC_UNDEFINED_LO  = 8'h00;
   localparam logic [7:0] FC_UNDEFINED_HI  = 8'hFF;
   localparam int         CYCLE_LIMIT      = 200000;
   localparam int         DRAIN_CYCLES     = 16;
   localparam int         N_PHASES         = 12;
   localparam int         ITEMS_PER_PHASE  = 44;
   localparam int         PRESSURE_PHASE   = 5;
   localparam int         HOLD_CYCLES      = 80;
   localparam int         N_DIRECTED       = 25;

   typedef struct packed {
      logic [1:0]  fill;
      logic [15:0] write_value;
      logic [10:0] element_offset;
      logic [10:0] quantity;
      logic [15:0] start_address;
      logic [7:0]  function_code;
   } req_t;

   typedef struct packed {
      logic [5:0]  fill;
      logic [15:0] read_value;
      logic [1:0]  status;
   } rsp_t;

   typedef struct packed {
      logic [1:0]  nt;
      logic [15:0] ws;
      logic [10:0] wl;
      logic [7:0]  fc;
      logic [15:0] addr;
      logic [10:0] qty;
      logic [10:0] off;
      logic [15:0] wval;
      logic        pin;
      logic [1:0]  st;
      logic [15:0] rd;
   } dir_row_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   logic [15:0] shadow_table [STORE_DEPTH];
   logic [1:0]  node_type_q     = NT_COILS;
   logic [15:0] window_start_q  = 16'd0;
   logic [10:0] window_length_q = 11'd1;

   rsp_t pending_replies [$];
   bit   pin_valid = 1'b0;
   rsp_t pin_value = '0;

   int failures           = 0;
   int requests_sent      = 0;
   int replies_checked    = 0;
   int config_count       = 0;
   int req_idle_pct       = 0;
   int rsp_stall_pct      = 0;
   int backpressure_left  = 0;

   dir_row_t directed_rows [N_DIRECTED] = '{
      '{NT_COILS, 16'd0, 11'd1, FC_READ_COILS, 16'd0, 11'd1, 11'd0, 16'h0000,
        1'b1, ST_OK, 16'h0000},
      '{NT_COILS, 16'd0, 11'd1, FC_WRITE_COIL, 16'd0, 11'd0, 11'd0, 16'h8000,
        1'b1, ST_OK, 16'h0000},
      '{NT_COILS, 16'd0, 11'd1, FC_READ_COILS, 16'd0, 11'd1, 11'd0, 16'h0000,
        1'b1, ST_OK, 16'h0001},
      '{NT_COILS, 16'd0, 11'd1, FC_WRITE_COILS, 16'd0, 11'd1, 11'd0, 16'hFFFE,
        1'b1, ST_OK, 16'h0000},
      '{NT_COILS, 16'd0, 11'd1, FC_READ_COILS, 16'd0, 11'd1, 11'd0, 16'h0000,
        1'b1, ST_OK, 16'h0000},
      '{NT_COILS, 16'd0, 11'd1, FC_WRITE_COIL, 16'd1, 11'd0, 11'd0, 16'h0001,
        1'b1, ST_BAD_ADDR, 16'h0000},
      '{NT_COILS, 16'd0, 11'd1, FC_READ_HOLDING, 16'd0, 11'd1, 11'd0, 16'h0000,
        1'b1, ST_BAD_FUNC, 16'h0000},
      '{NT_COILS, 16'd0, 11'd1, FC_UNDEFINED_LO, 16'd0, 11'd1, 11'd0, 16'h0000,
        1'b1, ST_BAD_FUNC, 16'h0000},
      '{NT_COILS, 16'd0, 11'd1, FC_UNDEFINED_HI, 16'hFFFF, 11'h7FF, 11'h7FF,
        16'hFFFF, 1'b1, ST_BAD_FUNC, 16'h0000},
      '{NT_COILS, 16'd0, 11'd1, FC_READ_COILS, 16'd0, 11'd0, 11'd0, 16'h0000,
        1'b1, ST_BAD_ADDR, 16'h0000},
      '{NT_HOLDING, 16'hFFFF, 11'd2047, FC_WRITE_REG, 16'hFFFF, 11'd0, 11'd0,
        16'hFFFF, 1'b1, ST_OK, 16'h0000},
      '{NT_HOLDING, 16'hFFFF, 11'd2047, FC_READ_HOLDING, 16'hFFFF, 11'd1, 11'd0,
        16'h0000, 1'b1, ST_OK, 16'hFFFF},
      '{NT_HOLDING, 16'hFFFF, 11'd2047, FC_WRITE_REGS, 16'hFFFF, 11'd2047,
        11'd2046, 16'h5A5A, 1'b1, ST_BAD_ADDR, 16'h0000},
      '{NT_HOLDING, 16'hFFFF, 11'd2047, FC_READ_HOLDING, 16'hFFFE, 11'd1, 11'd0,
        16'h0000, 1'b1, ST_BAD_ADDR, 16'h0000},
      '{NT_HOLDING, 16'd0, 11'd1024, FC_WRITE_REGS, 16'd0, 11'd1024, 11'd1023,
        16'h1234, 1'b1, ST_OK, 16'h0000},
      '{NT_HOLDING, 16'd0, 11'd1024, FC_READ_HOLDING, 16'd1000, 11'd24, 11'd23,
        16'h0000, 1'b1, ST_OK, 16'h1234},
      '{NT_HOLDING, 16'd0, 11'd1024, FC_WRITE_REGS, 16'd0, 11'd1025, 11'd0,
        16'hFFFF, 1'b1, ST_BAD_ADDR, 16'h0000},
      '{NT_HOLDING, 16'd0, 11'd1024, FC_WRITE_REG, 16'd1024, 11'h7FF, 11'h7FF,
        16'hBEEF, 1'b1, ST_BAD_ADDR, 16'h0000},
      '{NT_HOLDING, 16'd0, 11'd1024, FC_WRITE_REG, 16'd1023, 11'd0, 11'd0,
        16'hA5A5, 1'b1, ST_OK, 16'h0000},
      '{NT_INPUT_REG, 16'd0, 11'd1024, FC_READ_INPUT, 16'd1023, 11'd1, 11'd0,
        16'hFFFF, 1'b1, ST_OK, 16'hA5A5},
      '{NT_INPUT_REG, 16'd0, 11'd1024, FC_WRITE_REGS, 16'd0, 11'd1, 11'd0,
        16'h0001, 1'b1, ST_BAD_FUNC, 16'h0000},
      '{NT_INPUT_REG, 16'd0, 11'd1024, FC_READ_INPUT, 16'd5, 11'd3, 11'd3,
        16'h0000, 1'b1, ST_BAD_ADDR, 16'h0000},
      '{NT_DISCRETE, 16'd0, 11'd0, FC_READ_DISCRETE, 16'd0, 11'd1, 11'd0,
        16'h0000, 1'b1, ST_BAD_ADDR, 16'h0000},
      '{NT_DISCRETE, 16'd0, 11'd0, FC_READ_COILS, 16'd0, 11'd1, 11'd0,
        16'h0000, 1'b1, ST_BAD_FUNC, 16'h0000},
      '{NT_DISCRETE, 16'd0, 11'd8, FC_READ_DISCRETE, 16'd0, 11'd8, 11'd0,
        16'h0000, 1'b0, ST_OK, 16'h0000}
   };

   modbus_slave_data_table_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      foreach (shadow_table[i]) shadow_table[i] = 16'h0000;
   end

   // Applies one element access to the shadow store and returns the response.
   function automatic rsp_t table_access(req_t r);
      rsp_t        res;
      int unsigned served, ws, addr, qty, off, elem, idx;
      bit          single, allowed;
      res    = '0;
      elem   = 0;
      ws     = window_start_q;
      addr   = r.start_address;
      qty    = r.quantity;
      off    = r.element_offset;
      served = (window_length_q > STORE_DEPTH) ? STORE_DEPTH : window_length_q;
      single = (r.function_code == FC_WRITE_COIL) || (r.function_code == FC_WRITE_REG);
      case (node_type_q)
         NT_COILS: allowed = (r.function_code == FC_READ_COILS) ||
                             (r.function_code == FC_WRITE_COIL) ||
                             (r.function_code == FC_WRITE_COILS);
         NT_DISCRETE: allowed = (r.function_code == FC_READ_DISCRETE);
         NT_HOLDING: allowed = (r.function_code == FC_READ_HOLDING) ||
                               (r.function_code == FC_WRITE_REG) ||
                               (r.function_code == FC_WRITE_REGS);
         default: allowed = (r.function_code == FC_READ_INPUT);
      endcase
      if (!allowed) begin
         res.status = ST_BAD_FUNC;
      end else if (addr < ws) begin
         res.status = ST_BAD_ADDR;
      end else if (single) begin
         if (addr >= ws + served) res.status = ST_BAD_ADDR;
         else elem = addr;
      end else begin
         if (addr + qty > ws + served || off >= qty) res.status = ST_BAD_ADDR;
         else elem = addr + off;
      end
      if (res.status == ST_OK) begin
         idx = elem - ws;
         if (idx >= STORE_DEPTH) begin
            res.status = ST_BAD_ADDR;
         end else begin
            case (r.function_code)
               FC_READ_COILS, FC_READ_DISCRETE: begin
                  res.read_value = {15'd0, shadow_table[idx][0]};
               end
               FC_READ_HOLDING, FC_READ_INPUT: begin
                  res.read_value = shadow_table[idx];
               end
               FC_WRITE_COIL: begin
                  shadow_table[idx] = (r.write_value != 16'd0) ? 16'd1 : 16'd0;
               end
               FC_WRITE_COILS: begin
                  shadow_table[idx] = {15'd0, r.write_value[0]};
               end
               default: begin
                  shadow_table[idx] = r.write_value;
               end
            endcase
         end
      end
      return res;
   endfunction

   // Mostly well-formed accesses near the window start so that writes and
   // reads hit the same entries; the rest is unconstrained noise.
   function automatic req_t random_element(logic [1:0] nt, int unsigned ws,
                                           int unsigned wl);
      req_t        r;
      int unsigned served, span, rel, maxq;
      r      = req_t'({$urandom(), $urandom()});
      r.fill = '0;
      served = (wl > STORE_DEPTH) ? STORE_DEPTH : wl;
      if ($urandom_range(99) < 20 || served == 0) return r;
      case (nt)
         NT_COILS: begin
            case ($urandom_range(2))
               0: r.function_code = FC_READ_COILS;
               1: r.function_code = FC_WRITE_COIL;
               default: r.function_code = FC_WRITE_COILS;
            endcase
            if ($urandom_range(2) == 0) r.write_value = '0;
         end
         NT_DISCRETE: r.function_code = FC_READ_DISCRETE;
         NT_HOLDING: begin
            case ($urandom_range(2))
               0: r.function_code = FC_READ_HOLDING;
               1: r.function_code = FC_WRITE_REG;
               default: r.function_code = FC_WRITE_REGS;
            endcase
         end
         default: r.function_code = FC_READ_INPUT;
      endcase
      span = (ws + served > 65536) ? 65536 - ws : served;
      rel  = $urandom_range((span > 16 && $urandom_range(1) == 1) ? 15 : span - 1);
      if (r.function_code == FC_WRITE_COIL || r.function_code == FC_WRITE_REG) begin
         if ($urandom_range(9) == 0 && ws + served <= 65535) rel = served;
         r.start_address = 16'(ws + rel);
      end else begin
         r.start_address  = 16'(ws + rel);
         maxq             = served - rel;
         r.quantity       = 11'($urandom_range(1, (maxq > 8 && $urandom_range(3) != 0) ?
                                                  8 : maxq));
         r.element_offset = 11'($urandom_range(r.quantity - 1));
         if ($urandom_range(9) == 0) r.quantity = r.quantity + 11'd1;
      end
      return r;
   endfunction

   always @(posedge clock) begin : transfer_monitor
      rsp_t expected_reply, got;
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               CSR_NODE_TYPE: node_type_q = csr_wdata[1:0];
               CSR_WINDOW_START: window_start_q = csr_wdata;
               CSR_WINDOW_LENGTH: window_length_q = csr_wdata[10:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            expected_reply = table_access(req_t'(req_tdata));
            if (pin_valid) expected_reply = pin_value;
            pending_replies.push_back(expected_reply);
            requests_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_t'(rsp_tdata);
            if (pending_replies.size() == 0) begin
               $error("response with no request waiting: status %0d read_value %0h",
                      got.status, got.read_value);
               failures++;
            end else begin
               expected_reply = pending_replies.pop_front();
               replies_checked++;
               if (got.status !== expected_reply.status) begin
                  $error("status: expected %0d, actual %0d",
                         expected_reply.status, got.status);
                  failures++;
               end
               if (got.read_value !== expected_reply.read_value) begin
                  $error("read_value: expected %0h, actual %0h",
                         expected_reply.read_value, got.read_value);
                  failures++;
               end
            end
         end
      end
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (backpressure_left > 0) begin
            backpressure_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Run stopped at the cycle limit with %0d responses outstanding.",
               pending_replies.size());
      $display("modbus_slave_data_table_unit_tb: FAIL");
      $finish;
   end

   task automatic send_req(input req_t item, input bit pinned, input rsp_t pinned_reply);
      int gap;
      gap = 0;
      while (req_idle_pct > 0 && $urandom_range(99) < req_idle_pct) gap++;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      pin_valid = pinned;
      pin_value = pinned_reply;
      req_tvalid <= 1'b1;
      req_tdata  <= item;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic apply_config(input logic [1:0] nt, input logic [15:0] ws,
                               input logic [10:0] wl);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_NODE_TYPE;
      csr_wdata <= {14'd0, nt};
      @(negedge clock);
      csr_index <= CSR_WINDOW_START;
      csr_wdata <= ws;
      @(negedge clock);
      csr_index <= CSR_WINDOW_LENGTH;
      csr_wdata <= {5'd0, wl};
      @(negedge clock);
      csr_we <= 1'b0;
      config_count++;
   endtask

   initial begin
      req_t       item;
      rsp_t       reply;
      dir_row_t   row;
      logic [1:0]  cur_nt, nt;
      logic [15:0] cur_ws, ws;
      logic [10:0] cur_wl, wl;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = CSR_NODE_TYPE;
      csr_wdata  = '0;
      cur_nt     = NT_COILS;
      cur_ws     = 16'd0;
      cur_wl     = 11'd1;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // A write to the unassigned index must leave the window untouched.
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_UNUSED;
      csr_wdata <= 16'hFFFF;
      @(negedge clock);
      csr_we <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++) begin
         row = directed_rows[i];
         if (row.nt != cur_nt || row.ws != cur_ws || row.wl != cur_wl) begin
            apply_config(row.nt, row.ws, row.wl);
            cur_nt = row.nt;
            cur_ws = row.ws;
            cur_wl = row.wl;
         end
         item                = '0;
         item.function_code  = row.fc;
         item.start_address  = row.addr;
         item.quantity       = row.qty;
         item.element_offset = row.off;
         item.write_value    = row.wval;
         reply               = '0;
         reply.status        = row.st;
         reply.read_value    = row.rd;
         send_req(item, row.pin, reply);
      end

      for (int phase = 0; phase < N_PHASES; phase++) begin
         nt = 2'($urandom_range(3));
         case ($urandom_range(5))
            0: ws = 16'd0;
            1: ws = 16'hFFFF;
            2: ws = 16'($urandom());
            default: ws = 16'd100;
         endcase
         case ($urandom_range(6))
            0: wl = 11'd0;
            1: wl = 11'd1;
            2: wl = 11'd1024;
            3: wl = 11'd2047;
            4: wl = 11'($urandom_range(1, 2047));
            default: wl = 11'($urandom_range(2, 32));
         endcase
         apply_config(nt, ws, wl);
         case (phase % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 49; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 49; end
            default: begin req_idle_pct = 21; rsp_stall_pct = 21; end
         endcase
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            if (phase == PRESSURE_PHASE && k == 8) backpressure_left = HOLD_CYCLES;
            send_req(random_element(nt, ws, wl), 1'b0, '0);
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request transfers over %0d window settings and checked %0d responses.",
               requests_sent, config_count, replies_checked);
      $display("Idle mixes, one long receiver hold and %0d mismatches were seen.", failures);
      if (failures == 0) begin
         $display("modbus_slave_data_table_unit_tb: PASS");
      end else begin
         $display("modbus_slave_data_table_unit_tb: FAIL");
      end
      $finish;
   end

endmodule
